>>> hdl/earu_pkg.sv
// Shared widths, types, exp tables and saturation helpers for the attract/repel update.
package earu_pkg;

   localparam int COMP_W      = 20;
   localparam int FRAC_BITS   = 16;
   localparam int RATE_W      = 16;
   localparam int INVZ_W      = 24;
   localparam int SUM_W       = 46;
   localparam int ROOT_W      = SUM_W / 2;
   localparam int NUM_W       = COMP_W + FRAC_BITS;
   localparam int ITER_W      = $clog2(NUM_W);
   localparam int MAG_W       = COMP_W + 1;
   localparam int SQ_W        = 2 * MAG_W - 1;
   localparam int R_W         = 2 * FRAC_BITS - 4;
   localparam int E_W         = 17;
   localparam int C_W         = 25;
   localparam int Q_W         = 29;
   localparam int MUL_A_W     = 28;
   localparam int MUL_B_W     = 25;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int WIDE_W      = 32;
   localparam int IDX_W       = 8;
   localparam int N_REPEL     = 6;
   localparam int K_W         = 3;
   localparam int MAX_DIM_DEF = 64;

   localparam logic [RATE_W-1:0] ATTRACT_RATE_RST = RATE_W'(3277);
   localparam logic [INVZ_W-1:0] INV_Z_RST        = INVZ_W'(65536);

   // register indexes on the csr port
   localparam logic [IDX_W-1:0] REG_ATTRACT_RATE = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_INV_Z        = IDX_W'(1);

   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 32'sd524287;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -32'sd524288;

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      logic sqrt_go;
      logic div_go;
   } norm_cmd_type;

   localparam comp_type COMP_MAX = comp_type'(WIDE_MAX[COMP_W-1:0]);
   localparam comp_type COMP_MIN = comp_type'(WIDE_MIN[COMP_W-1:0]);

   // clamp a wide signed value to the component range
   function automatic comp_type sat_comp(input logic signed [WIDE_W-1:0] v);
      comp_type r;
      if (v > WIDE_MAX) r = COMP_MAX;
      else if (v < WIDE_MIN) r = COMP_MIN;
      else r = v[COMP_W-1:0];
      return r;
   endfunction

   // drop sixteen fraction bits, round half up (operands are magnitudes)
   function automatic logic [PROD_W-1:0] round_q16(input logic [PROD_W-1:0] p);
      return (p + PROD_W'(32768)) >> 16;
   endfunction

   // exp(-i), Q1.16
   function automatic logic [E_W-1:0] exp_int(input logic [3:0] i);
      logic [E_W-1:0] r;
      case (i)
         4'd0:    r = E_W'(65536);
         4'd1:    r = E_W'(24109);
         4'd2:    r = E_W'(8869);
         4'd3:    r = E_W'(3263);
         4'd4:    r = E_W'(1200);
         4'd5:    r = E_W'(442);
         4'd6:    r = E_W'(162);
         4'd7:    r = E_W'(60);
         4'd8:    r = E_W'(22);
         4'd9:    r = E_W'(8);
         4'd10:   r = E_W'(3);
         4'd11:   r = E_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // exp(-j/16), Q1.16
   function automatic logic [E_W-1:0] exp_frac(input logic [3:0] j);
      logic [E_W-1:0] r;
      case (j)
         4'd0:    r = E_W'(65536);
         4'd1:    r = E_W'(61565);
         4'd2:    r = E_W'(57835);
         4'd3:    r = E_W'(54331);
         4'd4:    r = E_W'(51039);
         4'd5:    r = E_W'(47947);
         4'd6:    r = E_W'(45042);
         4'd7:    r = E_W'(42313);
         4'd8:    r = E_W'(39750);
         4'd9:    r = E_W'(37341);
         4'd10:   r = E_W'(35079);
         4'd11:   r = E_W'(32954);
         4'd12:   r = E_W'(30957);
         4'd13:   r = E_W'(29081);
         4'd14:   r = E_W'(27319);
         default: r = E_W'(25664);
      endcase
      return r;
   endfunction

endpackage

>>> hdl/embedding_attract_repel_update.sv
// Top level of the attract/repel vector update with buffering and unit-length scaling.
// For each input word, one shared 28x25 multiplier is stepped through the attraction,
// six exp-weighted repulsions and two squares; the next word is taken only once idle.
// Closing a vector then runs the square roots, and each result word is divided by the
// 36-step restoring divider and waits while the receiver is not ready. Synchronous reset
// clears control, counters, square sums and the csr registers, not the component buffer.
module embedding_attract_repel_update import earu_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // user_comp, mr_comp, other_star_a, other_star_b, other_star_c, other_star_d,
   // rand_user_comp, rand_mr_comp, user_rate, mr_rate
   input  logic [191:0]         req_tdata,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // new_user_comp, new_mr_comp
   output logic [39:0]          rsp_tdata,
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [INVZ_W-1:0]    csr_data
);

   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef enum logic [18:0] {
      S_IDLE  = 19'h00001,
      S_ATT   = 19'h00002,
      S_ATT2  = 19'h00004,
      S_DIFF  = 19'h00008,
      S_SQ    = 19'h00010,
      S_E0    = 19'h00020,
      S_ER    = 19'h00040,
      S_C1    = 19'h00080,
      S_C     = 19'h00100,
      S_CM    = 19'h00200,
      S_APPLY = 19'h00400,
      S_SQU   = 19'h00800,
      S_SQM   = 19'h01000,
      S_ACC   = 19'h02000,
      S_SQRT  = 19'h04000,
      S_RD    = 19'h08000,
      S_LD    = 19'h10000,
      S_DIV   = 19'h20000,
      S_OUT   = 19'h40000
   } state_type;

   state_type            state_ff, state_in;
   logic [RATE_W-1:0]    attract_rate_ff;
   logic [INVZ_W-1:0]    inv_z_ff;

   // latched input word
   comp_type             ua_ff, ma_ff, ru_ff, rm_ff;
   comp_type             os_a_ff, os_b_ff, os_c_ff, os_d_ff;
   logic [RATE_W-1:0]    ur_ff, mrr_ff;
   logic                 last_ff;

   comp_type             nu_ff, nu_in, nm_ff, nm_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 ez_ff, ez_in;
   logic [R_W-1:0]       r_ff, r_in;
   logic [E_W-1:0]       e_ff, e_in;
   logic [PROD_W-1:0]    prod_ff;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   logic [SUM_W-1:0]     usum_ff, usum_in, msum_ff, msum_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, rd_ff, rd_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   comp_type             rsp_u_ff, rsp_u_in, rsp_m_ff, rsp_m_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [2*COMP_W-1:0]  mem [MAX_DIM];
   logic [2*COMP_W-1:0]  rd_data_ff;
   logic                 mem_we;

   norm_cmd_type         ncmd;
   logic                 nu_busy, nm_busy;
   comp_type             nu_res, nm_res;

   logic [MAG_W-1:0]     diff, diff_mag;
   comp_type             a_sel, o_sel;
   logic [RATE_W-1:0]    rate_sel;
   logic [PROD_W-1:0]    prod_rnd;
   logic [SQ_W-1:0]      x;
   logic [E_W-1:0]       e_fin;
   logic signed [WIDE_W-1:0] step_q, adj, sum_a, sum_b;
   logic [SUM_W:0]       usum_add, msum_add;
   logic [COMP_W-1:0]    nu_mag, nm_mag;
   logic                 req_acc, rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // write configuration, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         attract_rate_ff <= ATTRACT_RATE_RST;
         inv_z_ff        <= INV_Z_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ATTRACT_RATE: attract_rate_ff <= csr_data[RATE_W-1:0];
            REG_INV_Z:        inv_z_ff        <= csr_data;
            default:          ;
         endcase
      end
   end

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (req_acc) begin
         ua_ff   <= req_tdata[19:0];
         ma_ff   <= req_tdata[39:20];
         os_a_ff <= req_tdata[59:40];
         os_b_ff <= req_tdata[79:60];
         os_c_ff <= req_tdata[99:80];
         os_d_ff <= req_tdata[119:100];
         ru_ff   <= req_tdata[139:120];
         rm_ff   <= req_tdata[159:140];
         ur_ff   <= req_tdata[175:160];
         mrr_ff  <= req_tdata[191:176];
         last_ff <= req_tlast;
      end
   end

   // operand selection for the current repulsion
   always_comb begin
      a_sel    = (k_ff == '0) ? nu_ff : nm_ff;
      rate_sel = (k_ff == '0) ? ur_ff : mrr_ff;
      case (k_ff)
         3'd0:    o_sel = rm_ff;
         3'd1:    o_sel = ru_ff;
         3'd2:    o_sel = os_a_ff;
         3'd3:    o_sel = os_b_ff;
         3'd4:    o_sel = os_c_ff;
         default: o_sel = os_d_ff;
      endcase
      if (state_ff == S_ATT) diff = {ua_ff[COMP_W-1], ua_ff} - {ma_ff[COMP_W-1], ma_ff};
      else diff = {a_sel[COMP_W-1], a_sel} - {o_sel[COMP_W-1], o_sel};
      diff_mag = diff[MAG_W-1] ? -diff : diff;
      prod_rnd = round_q16(prod_ff);
      x        = prod_ff[SQ_W-1:0];
      e_fin    = ez_ff ? '0 : e_ff - prod_ff[2*FRAC_BITS+E_W-1:2*FRAC_BITS];
      nu_mag   = nu_ff[COMP_W-1] ? COMP_W'(-nu_ff) : COMP_W'(nu_ff);
      nm_mag   = nm_ff[COMP_W-1] ? COMP_W'(-nm_ff) : COMP_W'(nm_ff);
      step_q   = WIDE_W'(prod_rnd[Q_W-1:0]);
      adj      = neg_ff ? -step_q : step_q;
      sum_a    = WIDE_W'(ua_ff) - adj;
      sum_b    = WIDE_W'(ma_ff) + adj;
      usum_add = {1'b0, usum_ff} + (SUM_W+1)'(prod_ff[2*COMP_W-1:0]);
      msum_add = {1'b0, msum_ff} + (SUM_W+1)'(prod_ff[2*COMP_W-1:0]);
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_ATT: begin
            mul_a = MUL_A_W'(diff_mag);
            mul_b = MUL_B_W'(attract_rate_ff);
         end
         S_SQ: begin
            mul_a = MUL_A_W'(mag_ff);
            mul_b = MUL_B_W'(mag_ff);
         end
         S_E0: begin
            mul_a = MUL_A_W'(exp_int(x[2*FRAC_BITS+3:2*FRAC_BITS]));
            mul_b = MUL_B_W'(exp_frac(x[2*FRAC_BITS-1:2*FRAC_BITS-4]));
         end
         S_ER: begin
            mul_a = MUL_A_W'(r_ff);
            mul_b = MUL_B_W'(prod_rnd[E_W-1:0]);
         end
         S_C1: begin
            mul_a = MUL_A_W'(e_fin);
            mul_b = MUL_B_W'(rate_sel);
         end
         S_C: begin
            mul_a = MUL_A_W'(inv_z_ff);
            mul_b = MUL_B_W'(prod_rnd[E_W-1:0]);
         end
         S_CM: begin
            mul_a = MUL_A_W'(mag_ff);
            mul_b = MUL_B_W'(prod_rnd[C_W-1:0]);
         end
         S_SQU: begin
            mul_a = MUL_A_W'(nu_mag);
            mul_b = MUL_B_W'(nu_mag);
         end
         S_SQM: begin
            mul_a = MUL_A_W'(nm_mag);
            mul_b = MUL_B_W'(nm_mag);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      nu_in        = nu_ff;
      nm_in        = nm_ff;
      k_in         = k_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      ez_in        = ez_ff;
      r_in         = r_ff;
      e_in         = e_ff;
      usum_in      = usum_ff;
      msum_in      = msum_ff;
      cnt_in       = cnt_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_u_in     = rsp_u_ff;
      rsp_m_in     = rsp_m_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      ncmd         = '0;
      case (state_ff)
         S_IDLE: if (req_acc) state_in = S_ATT;
         S_ATT: begin
            neg_in   = diff[MAG_W-1];
            state_in = S_ATT2;
         end
         S_ATT2: begin
            nu_in    = sat_comp(sum_a);
            nm_in    = sat_comp(sum_b);
            k_in     = '0;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            mag_in   = diff_mag;
            neg_in   = diff[MAG_W-1];
            state_in = S_SQ;
         end
         S_SQ: state_in = S_E0;
         S_E0: begin
            ez_in    = |x[SQ_W-1:2*FRAC_BITS+4];
            r_in     = x[R_W-1:0];
            state_in = S_ER;
         end
         S_ER: begin
            e_in     = prod_rnd[E_W-1:0];
            state_in = S_C1;
         end
         S_C1:  state_in = S_C;
         S_C:   state_in = S_CM;
         S_CM:  state_in = S_APPLY;
         S_APPLY: begin
            if (k_ff == '0) nu_in = sat_comp(WIDE_W'(a_sel) + adj);
            else nm_in = sat_comp(WIDE_W'(a_sel) + adj);
            k_in = k_ff + K_W'(1);
            state_in = (k_ff == K_W'(N_REPEL - 1)) ? S_SQU : S_DIFF;
         end
         S_SQU: state_in = S_SQM;
         S_SQM: begin
            usum_in  = usum_add[SUM_W] ? '1 : usum_add[SUM_W-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            msum_in = msum_add[SUM_W] ? '1 : msum_add[SUM_W-1:0];
            mem_we  = 1'b1;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (last_ff || cnt_ff == CNT_W'(MAX_DIM - 1)) begin
               ncmd.sqrt_go = 1'b1;
               state_in     = S_SQRT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SQRT: begin
            rd_in = '0;
            if (!nu_busy && !nm_busy) state_in = S_RD;
         end
         S_RD: state_in = S_LD;
         S_LD: begin
            ncmd.div_go = 1'b1;
            state_in    = S_DIV;
         end
         S_DIV: if (!nu_busy && !nm_busy) state_in = S_OUT;
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_u_in     = nu_res;
               rsp_m_in     = nm_res;
               rsp_last_in  = (rd_ff + CNT_W'(1) == cnt_ff);
               if (rd_ff + CNT_W'(1) == cnt_ff) begin
                  usum_in  = '0;
                  msum_in  = '0;
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  rd_in    = rd_ff + CNT_W'(1);
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         usum_ff      <= '0;
         msum_ff      <= '0;
         cnt_ff       <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         usum_ff      <= usum_in;
         msum_ff      <= msum_in;
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nu_ff       <= nu_in;
      nm_ff       <= nm_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      ez_ff       <= ez_in;
      r_ff        <= r_in;
      e_ff        <= e_in;
      rsp_u_ff    <= rsp_u_in;
      rsp_m_ff    <= rsp_m_in;
      rsp_last_ff <= rsp_last_in;
   end

   // component buffer: user in the low half, movie in the high half
   always_ff @(posedge clock) begin
      if (mem_we) mem[cnt_ff[ADDR_W-1:0]] <= {nm_ff, nu_ff};
      rd_data_ff <= mem[rd_ff[ADDR_W-1:0]];
   end

   earu_norm u_norm_user (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ncmd),
      .sum    (usum_ff),
      .comp   (rd_data_ff[COMP_W-1:0]),
      .busy   (nu_busy),
      .result (nu_res)
   );

   // the movie sum takes its last square in the cycle the root starts
   earu_norm u_norm_movie (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ncmd),
      .sum    (msum_in),
      .comp   (rd_data_ff[2*COMP_W-1:COMP_W]),
      .busy   (nm_busy),
      .result (nm_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_m_ff, rsp_u_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> hdl/earu_norm.sv
// Bit-serial square root of a square sum, then restoring division of components by that root.
module earu_norm import earu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  norm_cmd_type       cmd,
   input  logic [SUM_W-1:0]   sum,
   input  comp_type           comp,
   output logic               busy,
   output comp_type           result
);

   localparam logic [SUM_W-1:0] BIT_START = SUM_W'(1) << (2 * (ROOT_W - 1));

   logic               busy_ff, busy_in;
   logic               div_ff, div_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [SUM_W-1:0]   v_ff, v_in;
   logic [SUM_W-1:0]   res_ff, res_in;
   logic [SUM_W-1:0]   bit_ff, bit_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [ROOT_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic               neg_ff, neg_in;
   comp_type           result_ff, result_in;

   logic [SUM_W:0]     sq_t;
   logic               sq_ge;
   logic [SUM_W-1:0]   sq_v, sq_res;
   logic [ROOT_W:0]    dv_trial, dv_diff;
   logic               dv_ge;
   logic [NUM_W-1:0]   dv_quo;
   logic               q_big;
   logic [COMP_W-1:0]  comp_mag;

   // one square root step: try the next bit pair
   always_comb begin
      sq_t   = {1'b0, res_ff} + {1'b0, bit_ff};
      sq_ge  = {1'b0, v_ff} >= sq_t;
      sq_v   = sq_ge ? v_ff - sq_t[SUM_W-1:0] : v_ff;
      sq_res = sq_ge ? (res_ff >> 1) + bit_ff : res_ff >> 1;
   end

   // one division step: bring down a numerator bit
   always_comb begin
      dv_trial = {rem_ff, num_ff[NUM_W-1]};
      dv_diff  = dv_trial - {1'b0, root_ff};
      dv_ge    = dv_trial >= {1'b0, root_ff};
      dv_quo   = {quo_ff[NUM_W-2:0], dv_ge};
      q_big    = |dv_quo[NUM_W-1:COMP_W-1];
      comp_mag = comp[COMP_W-1] ? COMP_W'(-comp) : COMP_W'(comp);
   end

   always_comb begin
      busy_in   = busy_ff;
      div_in    = div_ff;
      iter_in   = iter_ff;
      v_in      = v_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      root_in   = root_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      result_in = result_ff;
      if (cmd.sqrt_go) begin
         busy_in = 1'b1;
         div_in  = 1'b0;
         iter_in = ITER_W'(ROOT_W - 1);
         v_in    = sum;
         res_in  = '0;
         bit_in  = BIT_START;
      end else if (cmd.div_go) begin
         busy_in = 1'b1;
         div_in  = 1'b1;
         iter_in = ITER_W'(NUM_W - 1);
         num_in  = {comp_mag, FRAC_BITS'(0)} + NUM_W'(root_ff >> 1);
         rem_in  = '0;
         quo_in  = '0;
         neg_in  = comp[COMP_W-1];
      end else if (busy_ff && !div_ff) begin
         v_in   = sq_v;
         res_in = sq_res;
         bit_in = bit_ff >> 2;
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            root_in = sq_res[ROOT_W-1:0];
         end
      end else if (busy_ff) begin
         rem_in  = dv_ge ? dv_diff[ROOT_W-1:0] : dv_trial[ROOT_W-1:0];
         quo_in  = dv_quo;
         num_in  = num_ff << 1;
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == '0) begin
            busy_in = 1'b0;
            // saturate quotient and restore sign; a zero root gives zero
            if (root_ff == '0) result_in = '0;
            else if (neg_ff) result_in = q_big ? COMP_MIN : comp_type'(-dv_quo[COMP_W-1:0]);
            else result_in = q_big ? COMP_MAX : comp_type'(dv_quo[COMP_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff  <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         div_ff  <= div_in;
         iter_ff <= iter_in;
      end
      v_ff      <= v_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      root_ff   <= root_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign busy   = busy_ff;
   assign result = result_ff;

endmodule

>>> dv/tb_embedding_attract_repel_update.sv
// Self-checking testbench for the attract/repel vector update with unit-length scaling.
`timescale 1ns / 1ps

module tb_embedding_attract_repel_update;
   import earu_pkg::*;

   localparam int  N_DIM      = 64;
   localparam int  ITEM_GOAL  = 310;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  HOLD_LEN   = 600;
   localparam int  SETTLE_LEN = 150;
   localparam logic [IDX_W-1:0] REG_SPARE_LO = REG_INV_Z + IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_SPARE_HI = '1;

   localparam longint EXP_WHOLE[16] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60,
                                         22, 8, 3, 1, 0, 0, 0, 0};
   localparam longint EXP_SIXTEENTH[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                            45042, 42313, 39750, 37341, 35079, 32954,
                                            30957, 29081, 27319, 25664};

   typedef struct {
      comp_type          user_comp, mr_comp;
      comp_type          star_a, star_b, star_c, star_d;
      comp_type          rand_user, rand_mr;
      logic [RATE_W-1:0] user_rate, mr_rate;
      logic              last;
   } dim_word_type;

   typedef struct {
      comp_type user_comp, mr_comp;
      logic     last;
   } unit_word_type;

   // Predicts the normalised vector pair and checks the result words in order
   class unit_vector_board;
      longint         attract_rate, inv_z;
      longint         user_buf[N_DIM], mr_buf[N_DIM];
      longint         user_sq, mr_sq;
      int             dim_count;
      unit_word_type  unit_queue[$];
      int             errors;

      function new();
         attract_rate = 3277;
         inv_z        = 65536;
         user_sq      = 0;
         mr_sq        = 0;
         dim_count    = 0;
         errors       = 0;
      endfunction

      function int pending();
         return unit_queue.size();
      endfunction

      function void write_reg(logic [IDX_W-1:0] idx, logic [INVZ_W-1:0] value);
         if (idx == REG_ATTRACT_RATE) attract_rate = longint'(value[RATE_W-1:0]);
         else if (idx == REG_INV_Z) inv_z = longint'(value);
      endfunction

      function longint mag(longint x);
         return x < 0 ? -x : x;
      endfunction

      function longint round16(longint x);
         longint m;
         m = (mag(x) + 32768) >>> 16;
         return x < 0 ? -m : m;
      endfunction

      function longint clamp20(longint v);
         if (v > 524287) return 524287;
         if (v < -524288) return -524288;
         return v;
      endfunction

      // exp(-x) from the whole and sixteenth tables, x in Q.32
      function longint exp_neg(longint x);
         longint i, j, r, e;
         i = x >>> 32;
         if (i >= 16) return 0;
         j = (x >>> 28) & 15;
         r = x & ((longint'(1) << 28) - 1);
         e = (EXP_WHOLE[i] * EXP_SIXTEENTH[j] + 32768) >>> 16;
         return e - ((e * r) >>> 32);
      endfunction

      function longint repel(longint a, longint o, longint rate);
         longint d, c1, c;
         d  = a - o;
         c1 = (rate * exp_neg(mag(d) * mag(d)) + 32768) >>> 16;
         c  = (c1 * inv_z + 32768) >>> 16;
         return clamp20(a + round16(c * d));
      endfunction

      function longint isqrt(longint v);
         longint res, bit_v;
         res   = 0;
         bit_v = longint'(1) << 62;
         while (bit_v > v) bit_v = bit_v >>> 2;
         while (bit_v != 0) begin
            if (v >= res + bit_v) begin
               v   = v - (res + bit_v);
               res = (res >>> 1) + bit_v;
            end else begin
               res = res >>> 1;
            end
            bit_v = bit_v >>> 2;
         end
         return res;
      endfunction

      function comp_type scale(longint a, longint root);
         longint q;
         if (root == 0) return '0;
         q = ((mag(a) << FRAC_BITS) + root / 2) / root;
         if (q > (longint'(1) << 20)) q = longint'(1) << 20;
         return comp_type'(clamp20(a < 0 ? -q : q));
      endfunction

      function longint add_square(longint s, longint a);
         s = s + a * a;
         return s > ((longint'(1) << SUM_W) - 1) ? ((longint'(1) << SUM_W) - 1) : s;
      endfunction

      // Update one dimension; on the closing word queue the whole normalised pair
      function void note_word(dim_word_type w);
         longint ua, ma, nu, nm, user_root, mr_root;
         unit_word_type r;
         ua = longint'(w.user_comp);
         ma = longint'(w.mr_comp);
         nu = clamp20(ua - round16(attract_rate * (ua - ma)));
         nm = clamp20(ma - round16(attract_rate * (ma - ua)));
         nu = repel(nu, longint'(w.rand_mr), longint'(w.user_rate));
         nm = repel(nm, longint'(w.rand_user), longint'(w.mr_rate));
         nm = repel(nm, longint'(w.star_a), longint'(w.mr_rate));
         nm = repel(nm, longint'(w.star_b), longint'(w.mr_rate));
         nm = repel(nm, longint'(w.star_c), longint'(w.mr_rate));
         nm = repel(nm, longint'(w.star_d), longint'(w.mr_rate));
         if (dim_count >= N_DIM) dim_count = 0;
         user_buf[dim_count] = nu;
         mr_buf[dim_count]   = nm;
         user_sq = add_square(user_sq, nu);
         mr_sq   = add_square(mr_sq, nm);
         dim_count++;
         if (!w.last && dim_count < N_DIM) return;
         user_root = isqrt(user_sq);
         mr_root   = isqrt(mr_sq);
         for (int k = 0; k < dim_count; k++) begin
            r.user_comp = scale(user_buf[k], user_root);
            r.mr_comp   = scale(mr_buf[k], mr_root);
            r.last      = (k + 1 == dim_count);
            unit_queue.insert(unit_queue.size(), r);
         end
         user_sq   = 0;
         mr_sq     = 0;
         dim_count = 0;
      endfunction

      function void check_word(logic [39:0] data, logic last);
         unit_word_type e;
         if (unit_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h last %b", data, last);
            return;
         end
         e = unit_queue.pop_front();
         if (data[19:0] !== e.user_comp || data[39:20] !== e.mr_comp || last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected user %0d mr %0d last %b, got user %0d mr %0d last %b",
                        e.user_comp, e.mr_comp, e.last, comp_type'(data[19:0]),
                        comp_type'(data[39:20]), last);
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [191:0]        req_tdata;
   logic                req_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [39:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic [IDX_W-1:0]    csr_index;
   logic [INVZ_W-1:0]   csr_data;

   unit_vector_board board;
   int               send_idle_pct;
   int               recv_stall_pct;
   logic             holding;
   event             start_hold;
   int               cycle_count;
   int               words_sent;

   embedding_attract_repel_update u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns clock
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receive result words; stall at random or hold off for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_word(rsp_tdata, rsp_tlast);
         rsp_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Count out the long receiver hold-off
   initial begin
      forever begin
         @(start_hold);
         holding <= 1'b1;
         repeat (HOLD_LEN) @(posedge clock);
         holding <= 1'b0;
      end
   end

   function automatic comp_type any_comp();
      return comp_type'($urandom_range(0, (1 << COMP_W) - 1));
   endfunction

   function automatic comp_type near_comp(comp_type base);
      return comp_type'(base + comp_type'($urandom_range(0, 1 << 18)) - comp_type'(1 << 17));
   endfunction

   // Clustered words keep distances small so the exp weights stay live
   function automatic dim_word_type gen_word(bit clustered, logic last);
      dim_word_type w;
      comp_type     base;
      base = any_comp();
      if (clustered) begin
         w.user_comp = near_comp(base);
         w.mr_comp   = near_comp(base);
         w.star_a    = near_comp(base);
         w.star_b    = near_comp(base);
         w.star_c    = near_comp(base);
         w.star_d    = near_comp(base);
         w.rand_user = near_comp(base);
         w.rand_mr   = near_comp(base);
      end else begin
         w.user_comp = any_comp();
         w.mr_comp   = any_comp();
         w.star_a    = any_comp();
         w.star_b    = any_comp();
         w.star_c    = any_comp();
         w.star_d    = any_comp();
         w.rand_user = any_comp();
         w.rand_mr   = any_comp();
      end
      w.user_rate = RATE_W'($urandom_range(0, 65535));
      w.mr_rate   = RATE_W'($urandom_range(0, 65535));
      w.last      = last;
      return w;
   endfunction

   function automatic dim_word_type flat_word(comp_type u, comp_type m, comp_type o,
                                              logic [RATE_W-1:0] rate, logic last);
      dim_word_type w;
      w.user_comp = u;
      w.mr_comp   = m;
      w.star_a    = o;
      w.star_b    = o;
      w.star_c    = o;
      w.star_d    = o;
      w.rand_user = o;
      w.rand_mr   = o;
      w.user_rate = rate;
      w.mr_rate   = rate;
      w.last      = last;
      return w;
   endfunction

   // Offer one word after a random gap and wait for it to be taken
   task automatic send_word(dim_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w.mr_rate, w.user_rate, w.rand_mr, w.rand_user, w.star_d, w.star_c,
                     w.star_b, w.star_a, w.mr_comp, w.user_comp};
      req_tlast  <= w.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_word(w);
      words_sent++;
   endtask

   // Drop the request and wait until every result word is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [INVZ_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.write_reg(idx, value);
   endtask

   // Random vectors of mostly short length, optionally one that fills the buffer
   task automatic send_vectors(int n_words, bit fill_buffer);
      int stop_at;
      int len;
      stop_at = words_sent + n_words;
      if (fill_buffer)
         for (int k = 0; k < N_DIM; k++) send_word(gen_word($urandom_range(1), 1'b0));
      while (words_sent < stop_at) begin
         len = $urandom_range(1, 10);
         for (int k = 0; k < len; k++)
            send_word(gen_word($urandom_range(3) != 0, k == len - 1));
      end
   endtask

   initial begin
      board          = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = REG_ATTRACT_RATE;
      csr_data       = '0;
      holding        = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      cycle_count    = 0;
      words_sent     = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero vector, extremes, rates at both ends, close pulls
      send_word(flat_word('0, '0, '0, '0, 1'b1));
      send_word(flat_word(COMP_MAX, COMP_MAX, COMP_MAX, '1, 1'b0));
      send_word(flat_word(COMP_MIN, COMP_MIN, COMP_MIN, '1, 1'b0));
      send_word(flat_word(COMP_MAX, COMP_MIN, COMP_MIN, '1, 1'b0));
      send_word(flat_word(COMP_MIN, COMP_MAX, COMP_MAX, '0, 1'b1));
      send_word(flat_word(COMP_MAX, COMP_MIN, COMP_MAX, '1, 1'b1));
      send_word(flat_word(comp_type'(1000), comp_type'(-1000), comp_type'(10), '1, 1'b0));
      send_word(flat_word(comp_type'(65536), comp_type'(65000), comp_type'(70000), '1, 1'b0));
      send_word(flat_word(comp_type'(-1), comp_type'(1), '0, '1, 1'b1));
      send_word(gen_word(1'b1, 1'b1));
      drain();

      // Extreme register values, unused indexes ignored
      write_csr(REG_ATTRACT_RATE, '0);
      write_csr(REG_INV_Z, '0);
      write_csr(REG_SPARE_LO, '1);
      send_word(gen_word(1'b1, 1'b0));
      send_word(gen_word(1'b0, 1'b1));
      drain();
      write_csr(REG_ATTRACT_RATE, INVZ_W'(16'hFFFF));
      write_csr(REG_INV_Z, '1);
      write_csr(REG_SPARE_HI, '0);
      send_word(gen_word(1'b1, 1'b0));
      send_word(gen_word(1'b1, 1'b0));
      send_word(gen_word(1'b0, 1'b1));
      drain();

      // No idling, with a long receiver hold-off while words keep coming
      write_csr(REG_ATTRACT_RATE, INVZ_W'($urandom_range(0, 65535)));
      write_csr(REG_INV_Z, INVZ_W'($urandom_range(0, 1 << 18)));
      -> start_hold;
      send_vectors(60, 1'b0);
      drain();

      // Sender mostly idle; one vector runs to the buffer limit
      send_idle_pct = 81;
      write_csr(REG_ATTRACT_RATE, INVZ_W'(3277));
      write_csr(REG_INV_Z, INVZ_W'(65536));
      send_vectors(30, 1'b1);
      drain();

      // Receiver mostly stalling
      send_idle_pct  = 0;
      recv_stall_pct = 81;
      write_csr(REG_ATTRACT_RATE, INVZ_W'($urandom_range(0, 65535)));
      write_csr(REG_INV_Z, INVZ_W'($urandom_range(0, (1 << INVZ_W) - 1)));
      send_vectors(60, 1'b0);
      drain();

      // Both sides idle a quarter of the time
      send_idle_pct  = 25;
      recv_stall_pct = 25;
      write_csr(REG_ATTRACT_RATE, INVZ_W'($urandom_range(0, 65535)));
      write_csr(REG_INV_Z, INVZ_W'($urandom_range(32768, 1 << 20)));
      send_vectors(ITEM_GOAL - words_sent, 1'b0);
      drain();

      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
